// ----- rtl/core/rlcs_pkg.sv -----
// rlcs_pkg: shared constants, codes and types of the read-limited cell store
// used by rlcs_cell and read_limited_cell_store; depends on nothing
package rlcs_pkg;

  // defaults and fixed limits
  localparam int CELLS_DEF       = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_NUM         = 32;   // most cells that can be active
  localparam int TTL_MAX         = 1024;

  // field widths
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 6;
  localparam int TTL_W     = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_STORE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ_ONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_ALL = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CELLS_IN_USE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TTL_RELOAD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_ON_EXPIRY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic store;      // write the selected cell
    logic reload;     // load every count from the ttl bus
    logic start;      // place the token on the selected cell
    logic step;       // token cell reads, token moves one cell down
    logic ttl_zero;   // unlimited reads
    logic free_exp;   // empty a cell read after expiry
  } cell_cmd_t;

  // per-cell status, nonzero only on the token cell
  typedef struct packed {
    logic token;
    logic hit;        // token cell emits on this read
    logic last;       // no lower cell would emit
    logic present;
  } cell_stat_t;

endpackage

// ----- rtl/core/read_limited_cell_store.sv -----
// read_limited_cell_store: top level, controller and the chain of rlcs_cell
// depends on rlcs_pkg and rlcs_cell
//
// usage
//   in_*  : stream of items; store writes one cell, read-one reads one cell,
//           read-all reads the active cells from the highest index down to 0
//   out_* : stream of emitted cells; out_tlast marks the final result of an item
//   cfg_* : register writes, taken whenever cfg_we is high; the user must write
//           them only while idle, the block does not enforce it
// item handling
//   store: no result; the next item is taken in the next cycle
//   read-one: token on the cell; read and registered when the output register is free
//   read-all: a token walks down the chain one cell per cycle while the output
//           register is free; a result is registered as its cell is visited
//   out_tlast is known at once: each cell tells its upper neighbor whether
//   any cell below it would still emit
// reset
//   all cells empty, all counts zero, cells_in_use 1, ttl 0, free on expiry 1;
//   no clearing pass, the block takes items right after reset
// stall
//   while the output register holds a result not taken, the walk pauses;
//   in_tready stays low until the item is finished
module read_limited_cell_store #(
  parameter int CELLS       = rlcs_pkg::CELLS_DEF,
  parameter int VALUE_WIDTH = rlcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] kind, [6:2] cell_index, [38:7] store_value, [39] zero
  input  logic [rlcs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [4:0] out_cell, [36:5] out_value, [37] out_present, [39:38] zero
  output logic [rlcs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [rlcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rlcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // cell index width and active limit
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LIM   = (CELLS < rlcs_pkg::MAX_NUM) ? CELLS : rlcs_pkg::MAX_NUM;
  // stored value width: items carry 32 bits
  localparam int VW    = (VALUE_WIDTH < rlcs_pkg::DATA_W) ? VALUE_WIDTH : rlcs_pkg::DATA_W;

  // input fields
  logic [rlcs_pkg::KIND_W-1:0]  in_kind;
  logic [rlcs_pkg::INDEX_W-1:0] in_cell_index;
  logic [rlcs_pkg::DATA_W-1:0]  in_store_value;

  assign in_kind        = in_tdata[1:0];
  assign in_cell_index  = in_tdata[6:2];
  assign in_store_value = in_tdata[38:7];

  // configuration registers
  logic [rlcs_pkg::COUNT_W-1:0] n_r, n_nxt;       // active count, already saturated
  logic [rlcs_pkg::TTL_W-1:0]   ttl_r, ttl_nxt;
  logic                         free_r, free_nxt;
  logic [rlcs_pkg::TTL_W-1:0]   ttl_sat;
  logic [rlcs_pkg::COUNT_W-1:0] cfg_count;

  assign cfg_count = cfg_wdata[rlcs_pkg::COUNT_W-1:0];
  assign ttl_sat   = (cfg_wdata > rlcs_pkg::CFG_DATA_W'(rlcs_pkg::TTL_MAX))
                   ? rlcs_pkg::TTL_W'(rlcs_pkg::TTL_MAX) : cfg_wdata;

  always_comb begin
    n_nxt    = n_r;
    ttl_nxt  = ttl_r;
    free_nxt = free_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rlcs_pkg::REG_CELLS_IN_USE: begin
          if (cfg_count == '0) begin
            n_nxt = rlcs_pkg::COUNT_W'(1);
          end else if (cfg_count > rlcs_pkg::COUNT_W'(LIM)) begin
            n_nxt = rlcs_pkg::COUNT_W'(LIM);
          end else begin
            n_nxt = cfg_count;
          end
        end
        rlcs_pkg::REG_TTL_RELOAD:     ttl_nxt  = ttl_sat;
        rlcs_pkg::REG_FREE_ON_EXPIRY: free_nxt = cfg_wdata[0];
        default: ;  // no register there
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= rlcs_pkg::COUNT_W'(1);
      ttl_r  <= '0;
      free_r <= 1'b1;
    end else begin
      n_r    <= n_nxt;
      ttl_r  <= ttl_nxt;
      free_r <= free_nxt;
    end
  end

  // controller
  rlcs_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;          // cell under the token
  logic             single_r, single_nxt;    // read-one walk
  logic             in_xfer;
  logic             idx_ok;
  logic             slot_free;
  logic             do_store, do_start, do_step;
  logic [IDX_W-1:0] sel_idx;

  rlcs_pkg::cell_cmd_t cmd;

  // results gathered from the chain
  logic          hit_any, last_any, present_any;
  logic [VW-1:0] value_any;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [rlcs_pkg::INDEX_W-1:0]  out_cell_r, out_cell_nxt;
  logic [rlcs_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                          out_present_r, out_present_nxt;
  logic                          out_last_r, out_last_nxt;

  assign in_tready = (state_r == rlcs_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign idx_ok    = ({1'b0, in_cell_index} < n_r);
  assign slot_free = !out_valid_r || out_tready;

  // start cell: requested cell for read-one and store, top active cell for read-all
  assign sel_idx = (in_kind == rlcs_pkg::KIND_READ_ALL)
                 ? IDX_W'(n_r - 1'b1) : IDX_W'(in_cell_index);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    single_nxt = single_r;
    do_store   = 1'b0;
    do_start   = 1'b0;
    do_step    = 1'b0;
    unique case (state_r)
      rlcs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          priority if (in_kind == rlcs_pkg::KIND_STORE) begin
            do_store = idx_ok;
          end else if (in_kind == rlcs_pkg::KIND_READ_ONE) begin
            if (idx_ok) begin
              do_start   = 1'b1;
              single_nxt = 1'b1;
              idx_nxt    = sel_idx;
              state_nxt  = rlcs_pkg::ST_SCAN;
            end
          end else if (in_kind == rlcs_pkg::KIND_READ_ALL) begin
            do_start   = 1'b1;
            single_nxt = 1'b0;
            idx_nxt    = sel_idx;
            state_nxt  = rlcs_pkg::ST_SCAN;
          end else begin
            // unknown kind: dropped
          end
        end
      end
      rlcs_pkg::ST_SCAN: begin
        if (slot_free) begin
          do_step = 1'b1;
          if (single_r || idx_r == '0) begin
            state_nxt = rlcs_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = rlcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rlcs_pkg::ST_IDLE;
      idx_r    <= '0;
      single_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      single_r <= single_nxt;
    end
  end

  // a ttl write reloads every count from the new value
  assign cmd.store    = do_store;
  assign cmd.reload   = cfg_we && (cfg_index == rlcs_pkg::REG_TTL_RELOAD);
  assign cmd.start    = do_start;
  assign cmd.step     = do_step;
  assign cmd.ttl_zero = (ttl_r == '0);
  assign cmd.free_exp = free_r;

  logic [rlcs_pkg::TTL_W-1:0] ttl_bus;
  logic [VW-1:0]              wr_value;

  assign ttl_bus  = cmd.reload ? ttl_sat : ttl_r;
  assign wr_value = VW'(in_store_value);

  // the cell chain: token goes down, emit-below flag goes up
  logic                 token_vec [CELLS];
  logic                 emit_chain [CELLS+1];
  rlcs_pkg::cell_stat_t stat_vec [CELLS];
  logic [VW-1:0]        value_vec [CELLS];

  assign emit_chain[0] = 1'b0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic token_from_above;
    if (g == CELLS - 1) begin : g_top
      assign token_from_above = 1'b0;
    end else begin : g_mid
      assign token_from_above = token_vec[g+1];
    end

    rlcs_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .VW    (VW)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .sel_idx        (sel_idx),
      .wr_value       (wr_value),
      .ttl            (ttl_bus),
      .token_in       (token_from_above),
      .emit_below_in  (emit_chain[g]),
      .token_out      (token_vec[g]),
      .emit_below_out (emit_chain[g+1]),
      .stat           (stat_vec[g]),
      .rd_value       (value_vec[g])
    );
  end

  // only the token cell drives nonzero status, so an or over the row selects it
  always_comb begin
    hit_any     = 1'b0;
    last_any    = 1'b0;
    present_any = 1'b0;
    value_any   = '0;
    for (int i = 0; i < CELLS; i++) begin
      hit_any     = hit_any     | stat_vec[i].hit;
      last_any    = last_any    | stat_vec[i].last;
      present_any = present_any | stat_vec[i].present;
      value_any   = value_any   | value_vec[i];
    end
  end

  // output register, loaded when the token cell emits
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_cell_nxt    = out_cell_r;
    out_value_nxt   = out_value_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_step && hit_any) begin
      out_valid_nxt   = 1'b1;
      out_cell_nxt    = rlcs_pkg::INDEX_W'(idx_r);
      out_value_nxt   = rlcs_pkg::DATA_W'(value_any);
      out_present_nxt = present_any;
      out_last_nxt    = single_r || last_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cell_r    <= out_cell_nxt;
    out_value_r   <= out_value_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_present_r, out_value_r, out_cell_r};

  // checks
  logic [CELLS-1:0] token_bits;
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      token_bits[i] = token_vec[i];
    end
  end

  a_token_at_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcs_pkg::ST_SCAN) |-> ($onehot(token_bits) && token_bits[idx_r]))
    else $error("token not on the walked cell");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != '0) && (n_r <= rlcs_pkg::COUNT_W'(LIM)))
    else $error("active count out of range");

  a_ttl_range: assert property (@(posedge clk) disable iff (!rst_n)
    ttl_r <= rlcs_pkg::TTL_W'(rlcs_pkg::TTL_MAX))
    else $error("ttl above limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !do_step)
    else $error("walk advanced over a held result");

  a_read_one_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcs_pkg::ST_SCAN && single_r && do_step) |=> (state_r == rlcs_pkg::ST_IDLE))
    else $error("read-one walk did not end after one step");

endmodule

// ----- rtl/core/rlcs_cell.sv -----
// rlcs_cell: one cell of the store chain: value, present bit, read count, token
// depends on rlcs_pkg
module rlcs_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 5,
  parameter int VW     = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rlcs_pkg::cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]            sel_idx,
  input  logic [VW-1:0]               wr_value,
  input  logic [rlcs_pkg::TTL_W-1:0]  ttl,
  input  logic                        token_in,    // from the cell above
  input  logic                        emit_below_in,
  output logic                        token_out,
  output logic                        emit_below_out,
  output rlcs_pkg::cell_stat_t        stat,
  output logic [VW-1:0]               rd_value
);

  logic [VW-1:0]               value_r, value_nxt;
  logic                        present_r, present_nxt;
  logic [rlcs_pkg::TTL_W-1:0]  reads_r, reads_nxt;
  logic                        token_r, token_nxt;
  logic                        sel;
  logic                        can_emit;

  assign sel      = (sel_idx == IDX_W'(IDX));
  assign can_emit = cmd.ttl_zero || (reads_r != '0);

  always_comb begin
    value_nxt   = value_r;
    present_nxt = present_r;
    reads_nxt   = reads_r;
    token_nxt   = token_r;
    if (cmd.start) begin
      token_nxt = sel;
    end else if (cmd.step) begin
      token_nxt = token_in;
    end
    if (cmd.reload) begin
      reads_nxt = ttl;
    end
    if (cmd.store && sel) begin
      value_nxt   = wr_value;
      present_nxt = 1'b1;
      reads_nxt   = ttl;
    end
    if (cmd.step && token_r) begin
      if (!cmd.ttl_zero && reads_r != '0) begin
        reads_nxt = reads_r - 1'b1;
      end else if (!can_emit && cmd.free_exp) begin
        value_nxt   = '0;
        present_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      reads_r   <= '0;
      token_r   <= 1'b0;
    end else begin
      present_r <= present_nxt;
      reads_r   <= reads_nxt;
      token_r   <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign token_out      = token_r;
  assign emit_below_out = emit_below_in || can_emit;

  assign stat.token   = token_r;
  assign stat.hit     = token_r && can_emit;
  assign stat.last    = token_r && !emit_below_in;
  assign stat.present = token_r && present_r;
  assign rd_value     = (token_r && present_r) ? value_r : '0;

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for read_limited_cell_store
// drives item, result and register ports; checks every result against an in-bench cell model or a typed row
// depends on rlcs_pkg and the read_limited_cell_store rtl
`timescale 1ns / 1ps

module tb_top;
  import rlcs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;   // undefined kind, dropped by the block
  localparam int NRES_PREDICT    = -1;    // row result comes from the cell model
  localparam int SETTLE_CYCLES   = 40;    // wait for a full read-all walk to finish
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off in the pressure phase
  localparam int STALL_LIMIT     = 2000;  // cycles with no transfer before giving up
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 54;

  typedef enum {ROW_CFG, ROW_ITEM} row_act_t;

  // one emitted cell as seen on the result stream
  typedef struct packed {
    logic [INDEX_W-1:0] cell_id;
    logic [DATA_W-1:0]  value;
    logic               present;
    logic               last;
  } emit_t;

  // directed stimulus row; nres is NRES_PREDICT, 0 (nothing emitted) or 1 (typed result)
  typedef struct {
    row_act_t           act;
    logic [1:0]         code;     // kind for items, register index for writes
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  data;
    int                 nres;
    logic [INDEX_W-1:0] ecell;
    logic [DATA_W-1:0]  evalue;
    logic               epres;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [1:0] kind, [6:2] cell_index, [38:7] store_value, [39] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [4:0] out_cell, [36:5] out_value, [37] out_present, [39:38] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  read_limited_cell_store DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // cell model state and its copy of the registers
  logic [DATA_W-1:0] cell_val  [CELLS_DEF];
  logic              cell_full [CELLS_DEF];
  logic [TTL_W-1:0]  cell_left [CELLS_DEF];
  logic [COUNT_W-1:0] set_cells = 6'd1;
  logic [TTL_W-1:0]   set_ttl   = '0;
  logic               set_free  = 1'b1;

  emit_t emits_due [$];    // cells still to come out, oldest first
  emit_t step_emits [$];   // cells emitted by the item just taken
  row_t  dir_rows [$];

  // how the item now on the bus is checked, set by the sender before it raises tvalid
  int    exp_mode = NRES_PREDICT;
  emit_t exp_row;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int n_err = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < CELLS_DEF; i++) begin
      cell_val[i]  = '0;
      cell_full[i] = 1'b0;
      cell_left[i] = '0;
    end
  end

  // active count with zero read as one and anything past MAX_NUM clipped
  function automatic int active_cells();
    int n;
    n = set_cells;
    if (n < 1) n = 1;
    if (n > MAX_NUM) n = MAX_NUM;
    return n;
  endfunction

  // one read of a cell: true if it is emitted; counts down, and frees on expiry if set_free
  function automatic bit consume_read(int i);
    if (set_ttl == 0) return 1'b1;
    if (cell_left[i] != 0) begin
      cell_left[i] = cell_left[i] - 1'b1;
      return 1'b1;
    end
    if (set_free) begin
      cell_val[i]  = '0;
      cell_full[i] = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic emit_t cell_emit(int i);
    emit_t e;
    e.cell_id = i[INDEX_W-1:0];
    e.value   = cell_full[i] ? cell_val[i] : '0;
    e.present = cell_full[i];
    e.last    = 1'b0;
    return e;
  endfunction

  // applies one accepted item to the model and lists the cells it emits
  function automatic void predict_access(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                         logic [DATA_W-1:0] data);
    int n;
    emit_t e;
    n = active_cells();
    step_emits.delete();
    case (kind)
      KIND_STORE: begin
        if (idx < n) begin
          cell_val[idx]  = data;
          cell_full[idx] = 1'b1;
          cell_left[idx] = set_ttl;
        end
      end
      KIND_READ_ONE: begin
        if (idx < n && consume_read(idx)) step_emits.push_back(cell_emit(idx));
      end
      KIND_READ_ALL: begin
        // highest active cell first
        for (int i = n - 1; i >= 0; i--) begin
          if (consume_read(i)) step_emits.push_back(cell_emit(i));
        end
      end
      default: ;
    endcase
    if (step_emits.size() != 0) begin
      e = step_emits.pop_back();
      e.last = 1'b1;
      step_emits.push_back(e);
    end
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
    case (idx)
      REG_CELLS_IN_USE: set_cells = wdata[COUNT_W-1:0];
      REG_TTL_RELOAD: begin
        // ttl saturates, and every write reloads all counts
        set_ttl = (wdata > TTL_MAX) ? TTL_W'(TTL_MAX) : wdata;
        for (int i = 0; i < CELLS_DEF; i++) cell_left[i] = set_ttl;
      end
      REG_FREE_ON_EXPIRY: set_free = wdata[0];
      default: ;
    endcase
  endfunction

  // all transfers are seen here at the rising edge, results checked before the new item
  always @(posedge clk) begin : monitor
    emit_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (emits_due.size() == 0) begin
          $error("result transfer with nothing expected: out_cell %0d", out_tdata[4:0]);
          n_err++;
        end else begin
          e = emits_due.pop_front();
          if (out_tdata[4:0] !== e.cell_id) begin
            $error("out_cell mismatch: expected %0d, actual %0d", e.cell_id, out_tdata[4:0]);
            n_err++;
          end
          if (out_tdata[36:5] !== e.value) begin
            $error("out_value mismatch: expected %h, actual %h", e.value, out_tdata[36:5]);
            n_err++;
          end
          if (out_tdata[37] !== e.present) begin
            $error("out_present mismatch: expected %0b, actual %0b", e.present, out_tdata[37]);
            n_err++;
          end
          if (out_tlast !== e.last) begin
            $error("out_tlast mismatch: expected %0b, actual %0b", e.last, out_tlast);
            n_err++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        // the model always runs so that its state follows the block
        predict_access(in_tdata[1:0], in_tdata[6:2], in_tdata[38:7]);
        if (exp_mode == NRES_PREDICT) begin
          foreach (step_emits[k]) emits_due.push_back(step_emits[k]);
        end else if (exp_mode == 1) begin
          emits_due.push_back(exp_row);
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
    end
  end

  // watchdog: a long stretch with no transfer of any kind means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, or a counted hold-off that lets the block fill up
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offers one item at the falling edge and returns at the falling edge after its transfer;
  // tvalid stays high into the next item unless an idle cycle comes first
  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, data, idx, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // block idle: no item offered, every result in, and a full walk's time for silent read-alls
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (emits_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_row(row_act_t act, logic [1:0] code, logic [INDEX_W-1:0] idx,
                                  logic [DATA_W-1:0] data, int nres, logic [INDEX_W-1:0] ecell,
                                  logic [DATA_W-1:0] evalue, logic epres);
    row_t r;
    r.act = act;  r.code = code;  r.idx = idx;  r.data = data;
    r.nres = nres;  r.ecell = ecell;  r.evalue = evalue;  r.epres = epres;
    dir_rows.push_back(r);
  endfunction

  initial begin : main
    int counted;
    int n;
    int sel;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] cells_pick;
    logic [TTL_W-1:0]   ttl_pick;

    // after reset: one active cell, unlimited reads, free on expiry
    add_row(ROW_ITEM, KIND_READ_ONE, 0, 0, 1, 0, 0, 0);                  // empty cell emitted
    add_row(ROW_ITEM, KIND_READ_ALL, 31, 0, 1, 0, 0, 0);                 // index ignored
    add_row(ROW_ITEM, KIND_STORE, 1, 32'h1234_5678, 0, 0, 0, 0);         // index not active
    add_row(ROW_ITEM, KIND_STORE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ONE, 0, 0, 1, 0, 32'hFFFF_FFFF, 1);
    add_row(ROW_ITEM, KIND_UNUSED, 31, 32'hFFFF_FFFF, 0, 0, 0, 0);       // unknown kind dropped
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, 0, 0, 0, 0);                 // index not active
    add_row(ROW_CFG, REG_CELLS_IN_USE, 0, 63, 0, 0, 0, 0);               // clips to 32
    add_row(ROW_ITEM, KIND_STORE, 31, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_STORE, 17, 32'hA5A5_5A5A, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, 1, 31, 0, 1);
    add_row(ROW_ITEM, KIND_READ_ALL, 0, 0, NRES_PREDICT, 0, 0, 0);       // all 32 cells
    // two reads per value, then the cell expires and is freed
    add_row(ROW_CFG, REG_TTL_RELOAD, 0, 2, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, NRES_PREDICT, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, NRES_PREDICT, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, 0, 0, 0, 0);                 // expired
    add_row(ROW_ITEM, KIND_READ_ONE, 31, 0, 0, 0, 0, 0);                 // freed and expired
    add_row(ROW_ITEM, KIND_READ_ALL, 0, 0, NRES_PREDICT, 0, 0, 0);       // empty cells with count
    add_row(ROW_CFG, REG_FREE_ON_EXPIRY, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ALL, 0, 0, NRES_PREDICT, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ALL, 0, 0, 0, 0, 0, 0);                  // nothing left to emit
    add_row(ROW_CFG, REG_TTL_RELOAD, 0, 2047, 0, 0, 0, 0);               // saturates to 1024
    add_row(ROW_ITEM, KIND_READ_ONE, 0, 0, NRES_PREDICT, 0, 0, 0);
    add_row(ROW_CFG, REG_CELLS_IN_USE, 0, 0, 0, 0, 0, 0);                // zero acts as one
    add_row(ROW_CFG, REG_TTL_RELOAD, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, KIND_READ_ALL, 0, 0, NRES_PREDICT, 0, 0, 0);
    add_row(ROW_CFG, REG_FREE_ON_EXPIRY, 0, 1, 0, 0, 0, 0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    foreach (dir_rows[r]) begin
      if (dir_rows[r].act == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].code, dir_rows[r].data[CFG_DATA_W-1:0]);
      end else begin
        exp_mode        = dir_rows[r].nres;
        exp_row.cell_id = dir_rows[r].ecell;
        exp_row.value   = dir_rows[r].evalue;
        exp_row.present = dir_rows[r].epres;
        exp_row.last    = 1'b1;
        push_item(dir_rows[r].code, dir_rows[r].idx, dir_rows[r].data);
      end
    end

    // random part: each phase gets new settings and one of the idling modes
    exp_mode = NRES_PREDICT;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        // pressure phase: full bank, unlimited reads, read-alls pile up behind the hold-off
        cells_pick = 6'd32;
        ttl_pick   = '0;
      end else begin
        sel = $urandom_range(0, 7);
        cells_pick = (sel == 0) ? 6'd0 : (sel == 1) ? 6'd63 : (sel == 2) ? 6'd1 :
                     (sel == 3) ? 6'd32 : COUNT_W'($urandom_range(2, 31));
        sel = $urandom_range(0, 7);
        ttl_pick = (sel == 0) ? 11'd0 : (sel == 1) ? 11'd1024 : (sel == 2) ? 11'd2047 :
                   (sel == 3) ? 11'd1 : TTL_W'($urandom_range(1, 4));
      end
      write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(cells_pick));
      write_reg(REG_TTL_RELOAD, ttl_pick);
      write_reg(REG_FREE_ON_EXPIRY, CFG_DATA_W'($urandom_range(0, 1)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 0) hold_left = HOLD_CYCLES;
      n = active_cells();
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // mostly stores and reads into the active cells, a little noise
        sel = $urandom_range(0, 99);
        kind = (sel < 40) ? KIND_STORE : (sel < 75) ? KIND_READ_ONE :
               (sel < 93) ? KIND_READ_ALL : KIND_UNUSED;
        idx = ($urandom_range(0, 99) < 8) ? INDEX_W'($urandom_range(0, 31)) :
                                           INDEX_W'($urandom_range(0, n - 1));
        sel = $urandom_range(0, 9);
        data = (sel == 0) ? '0 : (sel == 1) ? '1 : DATA_W'($urandom);
        push_item(kind, idx, data);
        counted++;
      end
    end
    drain();

    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
